@@ design/timed_wavetable_oscillator_assert.svh @@
// ----------------------------------------------------------------------------
// Timed wavetable oscillator assertion macros
// Concurrent checks sampled on clock, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef TIMED_WAVETABLE_OSCILLATOR_ASSERT_SVH
`define TIMED_WAVETABLE_OSCILLATOR_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Condition must hold at every clock edge out of reset.
`define TWOSC_ASSERT_ALWAYS(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("timed_wavetable_oscillator: invariant violated");

// Consequent must hold in the same cycle as the antecedent.
`define TWOSC_ASSERT_IMPLY(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("timed_wavetable_oscillator: implication violated");

`else

`define TWOSC_ASSERT_ALWAYS(label, expr)
`define TWOSC_ASSERT_IMPLY(label, pre, post)

`endif

`endif

@@ design/twosc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twosc_pkg
// Shared types, constants and the quarter-wave sine table of the oscillator.
// ----------------------------------------------------------------------------
package twosc_pkg;

   localparam int TIME_W   = 48;
   localparam int PERIOD_W = 20;
   localparam int SAMPLE_W = 16;
   localparam int MODE_W   = 2;

   // Table points per cycle; must be a power of two.
   localparam int SINE_POINTS = 1024;
   localparam int SINE_W      = $clog2(SINE_POINTS);
   localparam int QTR_N       = SINE_POINTS / 4;
   localparam int QADDR_W     = SINE_W - 1;

   // Fraction bits of phase/period: enough for the saw and for the table index.
   localparam int SAW_W  = SAMPLE_W - 1;
   localparam int FRAC_W = (SINE_W > SAW_W) ? SINE_W : SAW_W;
   localparam int CNT_W  = $clog2(FRAC_W);

   localparam int QUEUE_DEPTH = 2;   // power of two
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic [PERIOD_W-1:0] RESET_PERIOD = PERIOD_W'(2272);
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

   localparam logic [63:0] Q30_ONE     = 64'd1073741824;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   typedef enum logic [MODE_W-1:0] {
      MODE_SINE   = 2'd0,
      MODE_SQUARE = 2'd1,
      MODE_SAW    = 2'd2,
      MODE_OFF    = 2'd3
   } wave_mode_type;

   // One classified transaction handed from front to back.
   typedef struct packed {
      logic                stale;
      logic [PERIOD_W-1:0] phase;
      logic [PERIOD_W-1:0] period;
   } twosc_item_type;

   typedef struct packed {
      logic            full;
      logic            not_empty;
      logic [QPTR_W:0] level;
   } queue_status_type;

   typedef struct packed {
      wave_mode_type rsp_mode;   // mode that produced the waiting result
   } back_status_type;

   typedef logic [SAW_W-1:0] quarter_rom_type [QTR_N+1];

   // Magnitudes of the first quarter cycle, entries 0 to QTR_N inclusive.
   function automatic quarter_rom_type build_quarter_rom();
      quarter_rom_type rom;
      logic [63:0]     r;
      logic [63:0]     a;
      logic [63:0]     x2;
      logic [63:0]     term;
      logic [63:0]     s;
      logic [63:0]     v;
      for (int i = 0; i <= QTR_N; i++) begin
         r    = (64'(i) << 32) / SINE_POINTS;
         a    = (r * HALF_PI_Q30) >> 30;
         x2   = (a * a) >> 30;
         term = Q30_ONE;
         term = Q30_ONE - ((x2 * term) >> 30) / 210;
         term = Q30_ONE - ((x2 * term) >> 30) / 156;
         term = Q30_ONE - ((x2 * term) >> 30) / 110;
         term = Q30_ONE - ((x2 * term) >> 30) / 72;
         term = Q30_ONE - ((x2 * term) >> 30) / 42;
         term = Q30_ONE - ((x2 * term) >> 30) / 20;
         term = Q30_ONE - ((x2 * term) >> 30) / 6;
         s    = (a * term) >> 30;
         v    = (s + 64'd16384) >> 15;
         if (v > 64'd32767) begin
            v = 64'd32767;
         end
         rom[i] = v[SAW_W-1:0];
      end
      return rom;
   endfunction

   localparam quarter_rom_type QUARTER_ROM = build_quarter_rom();

endpackage

@@ design/twosc_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twosc_front
// Accepts timestamps, tracks the cycle start and period, and classifies each
// transaction as stale or as a phase/period pair for the back end.
// ----------------------------------------------------------------------------
module twosc_front
   import twosc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [TIME_W-1:0]   req_time_us,
   input  logic [PERIOD_W-1:0] req_next_period_us,
   input  logic                queue_full,
   output logic                push,
   output twosc_item_type      item
);

   logic [TIME_W-1:0]   last_time_ff, last_time_in;
   logic [TIME_W-1:0]   cycle_start_ff, cycle_start_in;
   logic [PERIOD_W-1:0] period_ff, period_in;

   logic [TIME_W-1:0]   phase_full;
   logic                stale;
   logic                restart;
   logic [PERIOD_W-1:0] new_period;

   assign push       = req_valid && !queue_full;
   assign stale      = (req_time_us <= last_time_ff);
   assign phase_full = req_time_us - cycle_start_ff;
   assign restart    = (phase_full >= TIME_W'(period_ff));
   assign new_period = (req_next_period_us == '0) ? PERIOD_W'(1) : req_next_period_us;

   always_comb begin
      item.stale  = stale;
      item.phase  = restart ? '0 : phase_full[PERIOD_W-1:0];
      item.period = restart ? new_period : period_ff;
   end

   always_comb begin
      last_time_in   = last_time_ff;
      cycle_start_in = cycle_start_ff;
      period_in      = period_ff;
      if (push && !stale) begin
         last_time_in = req_time_us;
         if (restart) begin
            cycle_start_in = req_time_us;
            period_in      = new_period;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_time_ff   <= '0;
         cycle_start_ff <= '0;
         period_ff      <= RESET_PERIOD;
      end else begin
         last_time_ff   <= last_time_in;
         cycle_start_ff <= cycle_start_in;
         period_ff      <= period_in;
      end
   end

endmodule

@@ design/twosc_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twosc_queue
// Short register FIFO between front and back end.
// ----------------------------------------------------------------------------
module twosc_queue
   import twosc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  twosc_item_type   push_item,
   input  logic             pop,
   output twosc_item_type   pop_item,
   output queue_status_type status
);

   twosc_item_type    entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign do_push = push && (count_ff != (QPTR_W+1)'(QUEUE_DEPTH));
   assign do_pop  = pop && (count_ff != '0);

   assign pop_item         = entry_ff[rd_ptr_ff];
   assign status.full      = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign status.not_empty = (count_ff != '0);
   assign status.level     = count_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = wr_ptr_ff + QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + QPTR_W'(1);
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + (QPTR_W+1)'(1);
         2'b01:   count_in = count_ff - (QPTR_W+1)'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

@@ design/twosc_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twosc_back
// Turns a phase/period pair into a sample: bit-serial fraction divider,
// quarter-wave sine lookup, square and saw shaping, held sample, output stage.
// ----------------------------------------------------------------------------
module twosc_back
   import twosc_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  wave_mode_type              wave_mode,
   input  logic                       item_valid,
   input  twosc_item_type             item,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [SAMPLE_W-1:0] rsp_sample,
   output logic                       rsp_recomputed,
   output back_status_type            status
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_DIV  = 4'b0010,
      ST_ROM  = 4'b0100,
      ST_DONE = 4'b1000
   } back_state_type;

   back_state_type             state_ff, state_in;
   wave_mode_type              mode_ff, mode_in;
   logic [PERIOD_W-1:0]        per_ff, per_in;
   logic [PERIOD_W-1:0]        rem_ff, rem_in;
   logic [FRAC_W-1:0]          quot_ff, quot_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic signed [SAMPLE_W-1:0] res_ff, res_in;
   logic                       rec_ff, rec_in;
   logic signed [SAMPLE_W-1:0] held_ff, held_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_sample_ff, rsp_sample_in;
   logic                       rsp_rec_ff, rsp_rec_in;
   wave_mode_type              rsp_mode_ff, rsp_mode_in;

   logic                       out_free;
   logic                       deliver;
   logic [PERIOD_W:0]          rem_dbl;
   logic                       sub_ok;
   logic [FRAC_W-1:0]          quot_step;
   logic [SINE_W-1:0]          sine_idx;
   logic [1:0]                 quad;
   logic [QADDR_W-1:0]         qtr_addr;
   logic [SAW_W-1:0]           qtr_mag;
   logic signed [SAMPLE_W-1:0] sine_val;
   logic signed [SAMPLE_W-1:0] saw_val;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign deliver  = (state_ff == ST_DONE) && out_free;
   assign pop      = (state_ff == ST_IDLE) && item_valid;

   // One restoring step: remainder stays below the period.
   assign rem_dbl   = {rem_ff, 1'b0};
   assign sub_ok    = (rem_dbl >= {1'b0, per_ff});
   assign quot_step = {quot_ff[FRAC_W-2:0], sub_ok};

   // Fold the index onto the stored quarter cycle; mirror odd quadrants.
   assign sine_idx = quot_ff[FRAC_W-1 -: SINE_W];
   assign quad     = sine_idx[SINE_W-1 -: 2];
   assign qtr_addr = quad[0] ? (QADDR_W'(QTR_N) - {1'b0, sine_idx[SINE_W-3:0]})
                             : {1'b0, sine_idx[SINE_W-3:0]};
   assign qtr_mag  = QUARTER_ROM[qtr_addr];
   assign sine_val = quad[1] ? -$signed({1'b0, qtr_mag}) : $signed({1'b0, qtr_mag});
   assign saw_val  = $signed({1'b0, quot_step[FRAC_W-1 -: SAW_W]});

   always_comb begin
      state_in = state_ff;
      mode_in  = mode_ff;
      per_in   = per_ff;
      rem_in   = rem_ff;
      quot_in  = quot_ff;
      cnt_in   = cnt_ff;
      res_in   = res_ff;
      rec_in   = rec_ff;
      held_in  = held_ff;
      case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               mode_in = wave_mode;
               per_in  = item.period;
               rem_in  = item.phase;
               quot_in = '0;
               cnt_in  = CNT_W'(FRAC_W - 1);
               rec_in  = 1'b1;
               if (item.stale) begin
                  res_in   = held_ff;
                  rec_in   = 1'b0;
                  state_in = ST_DONE;
               end else begin
                  case (wave_mode)
                     MODE_SQUARE: begin
                        res_in   = (item.phase > (item.period >> 1)) ? SAMPLE_MAX
                                                                    : SAMPLE_MIN;
                        state_in = ST_DONE;
                     end
                     MODE_SINE, MODE_SAW: begin
                        state_in = ST_DIV;
                     end
                     default: begin
                        res_in   = '0;
                        state_in = ST_DONE;
                     end
                  endcase
               end
            end
         end
         ST_DIV: begin
            rem_in  = sub_ok ? PERIOD_W'(rem_dbl - {1'b0, per_ff}) : rem_dbl[PERIOD_W-1:0];
            quot_in = quot_step;
            cnt_in  = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               if (mode_ff == MODE_SAW) begin
                  res_in   = saw_val;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_ROM;
               end
            end
         end
         ST_ROM: begin
            res_in   = sine_val;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               if (rec_ff) begin
                  held_in = res_ff;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_sample_in = rsp_sample_ff;
      rsp_rec_in    = rsp_rec_ff;
      rsp_mode_in   = rsp_mode_ff;
      if (deliver) begin
         rsp_valid_in  = 1'b1;
         rsp_sample_in = res_ff;
         rsp_rec_in    = rec_ff;
         rsp_mode_in   = mode_ff;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      per_ff        <= per_in;
      rem_ff        <= rem_in;
      quot_ff       <= quot_in;
      cnt_ff        <= cnt_in;
      res_ff        <= res_in;
      rec_ff        <= rec_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_rec_ff    <= rsp_rec_in;
      rsp_mode_ff   <= rsp_mode_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_sample      = rsp_sample_ff;
   assign rsp_recomputed  = rsp_rec_ff;
   assign status.rsp_mode = rsp_mode_ff;

endmodule

@@ design/timed_wavetable_oscillator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timed_wavetable_oscillator
// Timestamp-driven sine/square/saw oscillator with Q1.15 output.
// ----------------------------------------------------------------------------
// Each request carries a microsecond timestamp and the period wanted from the
// frequency control; each yields exactly one response, in order. The front end
// takes a request whenever its two-entry queue has room, and the back end
// works on one transaction at a time. A stale timestamp, square mode and the
// unused mode go straight from idle to done in the back end; sawtooth and sine
// first run the one-bit-per-cycle phase/period divider (15 steps) and, for
// sine, the registered quarter-wave table read. A finished sample waits in
// the output register while the back end starts the next transaction. The
// wave mode is taken when the back end picks up a transaction.
module timed_wavetable_oscillator
   import twosc_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [TIME_W-1:0]          req_time_us,
   input  logic [PERIOD_W-1:0]        req_next_period_us,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [SAMPLE_W-1:0] rsp_sample,
   output logic                       rsp_recomputed,
   input  logic                       csr_write_enable,
   input  logic [MODE_W-1:0]          csr_write_data
);

`include "timed_wavetable_oscillator_assert.svh"

   wave_mode_type    wave_mode_ff, wave_mode_in;
   logic             push;
   twosc_item_type   push_item;
   logic             pop;
   twosc_item_type   pop_item;
   queue_status_type q_status;
   back_status_type  b_status;

   assign wave_mode_in = csr_write_enable ? wave_mode_type'(csr_write_data) : wave_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wave_mode_ff <= MODE_SINE;
      end else begin
         wave_mode_ff <= wave_mode_in;
      end
   end

   assign req_stall = q_status.full;

   twosc_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_time_us        (req_time_us),
      .req_next_period_us (req_next_period_us),
      .queue_full         (q_status.full),
      .push               (push),
      .item               (push_item)
   );

   twosc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .status    (q_status)
   );

   twosc_back u_back (
      .clock          (clock),
      .reset          (reset),
      .wave_mode      (wave_mode_ff),
      .item_valid     (q_status.not_empty),
      .item           (pop_item),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_sample     (rsp_sample),
      .rsp_recomputed (rsp_recomputed),
      .status         (b_status)
   );

   `TWOSC_ASSERT_ALWAYS(a_queue_level, q_status.level <= (QPTR_W+1)'(QUEUE_DEPTH))
   `TWOSC_ASSERT_IMPLY(a_square_rails, rsp_valid && rsp_recomputed && b_status.rsp_mode == MODE_SQUARE, rsp_sample == SAMPLE_MAX || rsp_sample == SAMPLE_MIN)
   `TWOSC_ASSERT_IMPLY(a_saw_positive, rsp_valid && rsp_recomputed && b_status.rsp_mode == MODE_SAW, !rsp_sample[SAMPLE_W-1])
   `TWOSC_ASSERT_IMPLY(a_off_silent, rsp_valid && rsp_recomputed && b_status.rsp_mode == MODE_OFF, rsp_sample == '0)

endmodule
